// ===== sv/kernel_centroid_recenter_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef KERNEL_CENTROID_RECENTER_UNIT_MACROS_SVH
`define KERNEL_CENTROID_RECENTER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define KCR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("kcr check failed");

// next-cycle implication, disabled in reset
`define KCR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("kcr check failed");

`endif

// ===== sv/kcr_pkg.sv =====
// shared constants, types and helper functions of the kernel recenter block
package kcr_pkg;

  localparam int MAX_SIDE    = 8;
  localparam int WEIGHT_BITS = 16;
  localparam int FB          = 12;
  localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
  localparam int AW          = $clog2(DEPTH);
  localparam int IW          = $clog2(MAX_SIDE);
  localparam int SIDE_W      = 4;
  localparam int SUM_W       = 24;
  localparam int MOM_W       = 27;
  localparam int NUM_W       = MOM_W + FB;
  localparam int Q_W         = NUM_W + 1;
  localparam int SRC_W       = Q_W + 2;
  localparam int FR_W        = FB + 1;
  localparam int CW_W        = FB + 3;
  localparam int COEF_W      = 2 * CW_W;
  localparam int PROD_W      = COEF_W + WEIGHT_BITS;
  localparam int ACC_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DAT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 4'd1;
  localparam logic [SIDE_W-1:0]    SIDE_RESET        = 4'd3;

  typedef struct packed {
    logic                    start;
    logic signed [MOM_W-1:0] num;
    logic signed [SUM_W-1:0] den;
  } kcr_div_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [Q_W-1:0] quo;
  } kcr_div_rsp_t;

  typedef struct packed {
    logic [IW-1:0]          i0;
    logic [IW-1:0]          i1;
    logic signed [FR_W-1:0] f;
  } kcr_split_t;

  // dimension register saturated to 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    else r = v;
    return r;
  endfunction

  // row-major store address
  function automatic logic [AW-1:0] store_addr(input logic [IW-1:0] y, input logic [IW-1:0] x,
                                               input logic [SIDE_W-1:0] w);
    logic [IW+SIDE_W-1:0] p;
    p = (IW+SIDE_W)'(y) * (IW+SIDE_W)'(w) + (IW+SIDE_W)'(x);
    return p[AW-1:0];
  endfunction

  // truncate toward zero, keep signed fraction, clamp indices
  function automatic kcr_split_t split_coord(input logic signed [SRC_W-1:0] s,
                                             input logic [SIDE_W-1:0] side);
    kcr_split_t r;
    logic neg;
    logic [SRC_W-1:0] mag;
    logic [SRC_W-FB-1:0] ipm;
    logic [FB-1:0] fm;
    logic [SIDE_W-1:0] top;
    neg = s[SRC_W-1];
    mag = neg ? (~s + 1'b1) : s;
    ipm = mag[SRC_W-1:FB];
    fm  = mag[FB-1:0];
    top = side - SIDE_W'(1);
    r.f = neg ? -$signed({1'b0, fm}) : $signed({1'b0, fm});
    if (neg) r.i0 = '0;
    else if (ipm > (SRC_W-FB)'(top)) r.i0 = top[IW-1:0];
    else r.i0 = ipm[IW-1:0];
    r.i1 = ({1'b0, r.i0} + SIDE_W'(1) > top) ? top[IW-1:0] : r.i0 + IW'(1);
    return r;
  endfunction

  // round to nearest, ties away from zero, then saturate
  function automatic logic [WEIGHT_BITS-1:0] round_sat(input logic signed [ACC_W-1:0] p);
    logic neg;
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-2*FB-1:0] rm;
    logic [WEIGHT_BITS-1:0] r;
    neg = p[ACC_W-1];
    mag = neg ? (~p + 1'b1) : p;
    sum = mag + (ACC_W'(1) << (2*FB-1));
    rm  = sum[ACC_W-1:2*FB];
    if (neg) begin
      if (rm > (ACC_W-2*FB)'(1) << (WEIGHT_BITS-1)) r = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
      else r = ~rm[WEIGHT_BITS-1:0] + 1'b1;
    end else begin
      if (rm > ((ACC_W-2*FB)'(1) << (WEIGHT_BITS-1)) - 1'b1) r = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
      else r = rm[WEIGHT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/kcr_ifs.sv =====
// valid/ready channel interfaces of the kernel recenter block
interface kcr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [kcr_pkg::WEIGHT_BITS-1:0] weight_in;
  modport source (output valid, output weight_in, input ready);
  modport sink   (input valid, input weight_in, output ready);
endinterface

interface kcr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [kcr_pkg::WEIGHT_BITS-1:0] weight_out;
  logic                                last_out;
  modport source (output valid, output weight_out, output last_out, input ready);
  modport sink   (input valid, input weight_out, input last_out, output ready);
endinterface

interface kcr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kcr_pkg::CFG_IDX_W-1:0]     index;
  logic [kcr_pkg::CFG_DAT_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/kernel_centroid_recenter_unit.sv =====
// kernel centroid recenter: load, divide, bilinear resample and emit
//
//  channel  dir  payload                       accepted when
//  in_if    in   weight_in (16 signed)         valid && ready
//  out_if   out  weight_out (16 signed), last  valid && ready
//  cfg_if   in   index (4), data (4)           valid && ready (ready always high)
//
// load takes one weight per cycle; the weight store is one ram with a registered read.
// after the last weight two 39-step divisions run (skipped for a zero weight sum).
// each result then takes 4 taps of read, multiply and accumulate, or a single stored
// weight copy for a zero weight sum, plus any stall of the output register.
// reset is asynchronous active low; the store needs no clearing pass.
// new weights are taken while the last result of a kernel still waits.
module kernel_centroid_recenter_unit (
  input  logic clk_i,
  input  logic rst_ni,
  kcr_in_if.sink    in_if,
  kcr_out_if.source out_if,
  kcr_cfg_if.sink   cfg_if
);
  import kcr_pkg::*;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_DX0   = 4'd1;
  localparam logic [3:0] ST_DX1   = 4'd2;
  localparam logic [3:0] ST_DY0   = 4'd3;
  localparam logic [3:0] ST_DY1   = 4'd4;
  localparam logic [3:0] ST_COORD = 4'd5;
  localparam logic [3:0] ST_SPLIT = 4'd6;
  localparam logic [3:0] ST_RD    = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_ACC   = 4'd9;
  localparam logic [3:0] ST_RND   = 4'd10;

  localparam logic signed [CW_W-1:0] ONE_W = CW_W'(1) << FB;

  logic [3:0]              state_q, state_d;
  logic [SIDE_W-1:0]       width_q, height_q, ws, hs;
  logic [IW-1:0]           lx_q, ly_q, ox_q, oy_q;
  logic [AW-1:0]           pos_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [MOM_W-1:0] cm_q, rm_q;
  logic signed [Q_W-1:0]   cx_q, cy_q;
  logic signed [SRC_W-1:0] sx_q, sy_q;
  kcr_split_t              spx_q, spy_q;
  logic [1:0]              tap_q;
  logic signed [COEF_W-1:0] coef_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic [WEIGHT_BITS-1:0]   raw_q;
  logic                     zero_q;
  logic                     ov_q, ol_q;
  logic [WEIGHT_BITS-1:0]   ow_q;

  logic in_acc, cfg_wr, last_in, last_out_pos, slot_free;
  logic signed [WEIGHT_BITS-1:0] v;
  logic signed [IW+WEIGHT_BITS:0] cmul, rmul;
  logic [AW-1:0] raddr;
  logic [WEIGHT_BITS-1:0] rdata;
  logic signed [CW_W-1:0] wa, wb;
  kcr_div_req_t div_req;
  kcr_div_rsp_t div_rsp;

  assign ws = eff_side(width_q);
  assign hs = eff_side(height_q);
  assign in_if.ready  = (state_q == ST_LOAD);
  assign cfg_if.ready = 1'b1;
  assign in_acc = in_if.valid && in_if.ready;
  assign cfg_wr = cfg_if.valid && cfg_if.ready;
  assign v = in_if.weight_in;
  assign last_in = ({1'b0, lx_q} == ws - SIDE_W'(1)) && ({1'b0, ly_q} == hs - SIDE_W'(1));
  assign last_out_pos = ({1'b0, ox_q} == ws - SIDE_W'(1)) && ({1'b0, oy_q} == hs - SIDE_W'(1));
  assign slot_free = !ov_q || out_if.ready;
  assign cmul = $signed({1'b0, lx_q}) * v;
  assign rmul = $signed({1'b0, ly_q}) * v;

  // weight store
  kcr_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (pos_q),
    .wdata_i (v),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // centroid divider
  always_comb begin
    div_req.start = (state_q == ST_DX0 && sum_q != '0) || (state_q == ST_DY0);
    div_req.num   = (state_q == ST_DY0) ? rm_q : cm_q;
    div_req.den   = sum_q;
  end

  kcr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // tap address and bilinear weights
  always_comb begin
    if (zero_q) raddr = store_addr(oy_q, ox_q, ws);
    else raddr = store_addr(tap_q[1] ? spy_q.i1 : spy_q.i0,
                            tap_q[0] ? spx_q.i1 : spx_q.i0, ws);
    wa = tap_q[0] ? CW_W'(spx_q.f) : ONE_W - CW_W'(spx_q.f);
    wb = tap_q[1] ? CW_W'(spy_q.f) : ONE_W - CW_W'(spy_q.f);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (in_acc && last_in) state_d = ST_DX0;
      ST_DX0:   state_d = (sum_q == '0) ? ST_COORD : ST_DX1;
      ST_DX1:   if (div_rsp.done) state_d = ST_DY0;
      ST_DY0:   state_d = ST_DY1;
      ST_DY1:   if (div_rsp.done) state_d = ST_COORD;
      ST_COORD: state_d = zero_q ? ST_RD : ST_SPLIT;
      ST_SPLIT: state_d = ST_RD;
      ST_RD:    state_d = ST_MUL;
      ST_MUL:   state_d = zero_q ? ST_RND : ST_ACC;
      ST_ACC:   state_d = (tap_q == 2'd3) ? ST_RND : ST_RD;
      ST_RND:   if (slot_free) state_d = last_out_pos ? ST_LOAD : ST_COORD;
      default:  state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      width_q  <= SIDE_RESET;
      height_q <= SIDE_RESET;
      lx_q <= '0; ly_q <= '0; pos_q <= '0;
      sum_q <= '0; cm_q <= '0; rm_q <= '0;
      ox_q <= '0; oy_q <= '0; tap_q <= '0;
      zero_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (slot_free) ov_q <= 1'b0;
      if (cfg_wr) begin
        if (cfg_if.index == REG_KERNEL_WIDTH) width_q <= cfg_if.data;
        if (cfg_if.index == REG_KERNEL_HEIGHT) height_q <= cfg_if.data;
        if (cfg_if.index == REG_KERNEL_WIDTH || cfg_if.index == REG_KERNEL_HEIGHT) begin
          lx_q <= '0; ly_q <= '0; pos_q <= '0;
          sum_q <= '0; cm_q <= '0; rm_q <= '0;
        end
      end else if (in_acc) begin
        sum_q <= sum_q + SUM_W'(v);
        cm_q  <= cm_q + MOM_W'(cmul);
        rm_q  <= rm_q + MOM_W'(rmul);
        if (last_in) begin
          lx_q <= '0; ly_q <= '0; pos_q <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
          if ({1'b0, lx_q} == ws - SIDE_W'(1)) begin
            lx_q <= '0;
            ly_q <= ly_q + 1'b1;
          end else begin
            lx_q <= lx_q + 1'b1;
          end
        end
      end
      if (state_q == ST_DX0) begin
        zero_q <= (sum_q == '0);
        ox_q <= '0;
        oy_q <= '0;
      end
      if (state_q == ST_COORD) tap_q <= '0;
      if (state_q == ST_ACC) tap_q <= tap_q + 1'b1;
      if (state_q == ST_RND && slot_free) begin
        ov_q <= 1'b1;
        if (last_out_pos) begin
          sum_q <= '0; cm_q <= '0; rm_q <= '0;
        end else if ({1'b0, ox_q} == ws - SIDE_W'(1)) begin
          ox_q <= '0;
          oy_q <= oy_q + 1'b1;
        end else begin
          ox_q <= ox_q + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DX1 && div_rsp.done) cx_q <= div_rsp.quo;
    if (state_q == ST_DX0) begin
      cx_q <= '0;
      cy_q <= '0;
    end
    if (state_q == ST_DY1 && div_rsp.done) cy_q <= div_rsp.quo;
    if (state_q == ST_COORD) begin
      sx_q <= $signed({{(SRC_W-IW-FB){1'b0}}, ox_q, {FB{1'b0}}})
            - $signed({{(SRC_W-SIDE_W-FB+1){1'b0}}, ws - SIDE_W'(1), {(FB-1){1'b0}}})
            + SRC_W'(cx_q);
      sy_q <= $signed({{(SRC_W-IW-FB){1'b0}}, oy_q, {FB{1'b0}}})
            - $signed({{(SRC_W-SIDE_W-FB+1){1'b0}}, hs - SIDE_W'(1), {(FB-1){1'b0}}})
            + SRC_W'(cy_q);
    end
    if (state_q == ST_SPLIT) begin
      spx_q <= split_coord(sx_q, ws);
      spy_q <= split_coord(sy_q, hs);
      acc_q <= '0;
    end
    if (state_q == ST_RD) coef_q <= wa * wb;
    if (state_q == ST_MUL) begin
      raw_q  <= rdata;
      prod_q <= coef_q * $signed(rdata);
    end
    if (state_q == ST_ACC) acc_q <= acc_q + ACC_W'(prod_q);
    if (state_q == ST_RND && slot_free) begin
      ow_q <= zero_q ? raw_q : round_sat(acc_q);
      ol_q <= last_out_pos;
    end
  end

  assign out_if.valid      = ov_q;
  assign out_if.weight_out = ow_q;
  assign out_if.last_out   = ol_q;
endmodule

// ===== sv/kcr_ram.sv =====
// generic single-port-write ram with registered read
module kcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== sv/kcr_div.sv =====
// restoring signed divider, one quotient bit per cycle
module kcr_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kcr_pkg::kcr_div_req_t req_i,
  output kcr_pkg::kcr_div_rsp_t rsp_o
);
  import kcr_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] n_q, q_q;
  logic [SUM_W-1:0] r_q, d_q;
  logic [MOM_W-1:0] nmag;
  logic [SUM_W-1:0] dmag;
  logic [SUM_W:0]   rs, rn;
  logic             ge;

  assign nmag = req_i.num[MOM_W-1] ? (~req_i.num + 1'b1) : req_i.num;
  assign dmag = req_i.den[SUM_W-1] ? (~req_i.den + 1'b1) : req_i.den;

  // one trial subtraction
  assign rs = {r_q, n_q[NUM_W-1]};
  assign ge = rs >= {1'b0, d_q};
  assign rn = ge ? rs - {1'b0, d_q} : rs;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q   <= {nmag, {FB{1'b0}}};
      d_q   <= dmag;
      r_q   <= '0;
      q_q   <= '0;
      neg_q <= req_i.num[MOM_W-1] ^ req_i.den[SUM_W-1];
    end else if (busy_q) begin
      n_q <= {n_q[NUM_W-2:0], 1'b0};
      r_q <= rn[SUM_W-1:0];
      q_q <= {q_q[NUM_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
endmodule

// ===== sv/kcr_checker.sv =====
// port-level checks of the kernel recenter block, bound to the top level
`include "kernel_centroid_recenter_unit_macros.svh"

module kcr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);
  // a result stays offered until taken
  `KCR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // no loading while a kernel is being emitted
  `KCR_ASSERT_IMP(a_no_load_mid, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i)

  // results never start right on an accepted weight
  `KCR_ASSERT_IMP(a_emit_gap, clk_i, rst_ni, $rose(out_valid_i), !$past(in_valid_i && in_ready_i))
endmodule

bind kernel_centroid_recenter_unit kcr_checker u_kcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_last_i  (out_if.last_out)
);
